### sv/ptuc_pkg.sv
package ptuc_pkg;

  // Sizes
  localparam int unsigned FRAME_COUNT     = 256;
  localparam int unsigned SLOTS_PER_TABLE = 512;
  localparam int unsigned FRAME_AW        = $clog2(FRAME_COUNT);
  localparam int unsigned SLOT_IW         = $clog2(SLOTS_PER_TABLE);
  localparam int unsigned SLOT_AW         = FRAME_AW + SLOT_IW;
  localparam int unsigned SLOT_DEPTH      = FRAME_COUNT * SLOTS_PER_TABLE;
  // a slot holds frame number plus one, zero when empty
  localparam int unsigned SLOT_DW         = $clog2(FRAME_COUNT + 1);

  // Field widths
  localparam int unsigned FRAME_W = 9;
  localparam int unsigned SLOTF_W = 10;
  localparam int unsigned OWNER_W = 8;
  localparam int unsigned ENTRY_W = 10;
  localparam int unsigned REF_W   = 18;

  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0,
    KIND_L4    = 3'd1,
    KIND_L3    = 3'd2,
    KIND_L2    = 3'd3,
    KIND_L1    = 3'd4,
    KIND_DATA  = 3'd5
  } frame_kind_e;

  typedef enum logic [1:0] {
    ACT_META  = 2'd0,
    ACT_MAP   = 2'd1,
    ACT_UNMAP = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Per-frame word: metadata plus table entry count
  typedef struct packed {
    logic [2:0]         kind;
    logic               shared;
    logic [OWNER_W-1:0] owner;
    logic [ENTRY_W-1:0] entries;
  } frame_word_t;

  typedef struct packed {
    logic                re;
    logic [FRAME_AW-1:0] raddr_tf;
    logic [FRAME_AW-1:0] raddr_tg;
    logic                we;
    logic [FRAME_AW-1:0] waddr;
    frame_word_t         wdata;
  } frame_req_t;

  typedef struct packed {
    logic                re;
    logic [FRAME_AW-1:0] raddr;
    logic                we;
    logic [FRAME_AW-1:0] waddr;
    logic [REF_W-1:0]    wdata;
  } ref_req_t;

  typedef struct packed {
    logic               re;
    logic [SLOT_AW-1:0] raddr;
    logic               we;
    logic [SLOT_AW-1:0] waddr;
    logic [SLOT_DW-1:0] wdata;
  } slot_req_t;

endpackage

### sv/ptuc_ram.sv
module ptuc_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ptuc_ctrl.sv
module ptuc_ctrl (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // owner register write
  input  logic                                     cfg_valid_i,
  input  logic [ptuc_pkg::OWNER_W-1:0]             cfg_data_i,
  // request channel
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [1:0]                               action_i,
  input  logic [1:0]                               level_i,
  input  logic [ptuc_pkg::FRAME_W-1:0]             table_frame_i,
  input  logic [ptuc_pkg::SLOTF_W-1:0]             slot_i,
  input  logic [ptuc_pkg::FRAME_W-1:0]             target_frame_i,
  input  logic [2:0]                               new_kind_i,
  input  logic                                     new_shared_i,
  input  logic [ptuc_pkg::OWNER_W-1:0]             new_owner_i,
  // result channel
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic                                     status_o,
  output logic [ptuc_pkg::ENTRY_W-1:0]             table_entries_used_o,
  output logic [ptuc_pkg::REF_W-1:0]               target_references_o,
  // memory side
  output ptuc_pkg::frame_req_t                     frame_req_o,
  output ptuc_pkg::ref_req_t                       ref_req_o,
  output ptuc_pkg::slot_req_t                      slot_req_o,
  input  ptuc_pkg::frame_word_t                    tf_word_i,
  input  ptuc_pkg::frame_word_t                    tg_word_i,
  input  logic [ptuc_pkg::REF_W-1:0]               ref_rdata_i,
  input  logic [ptuc_pkg::SLOT_DW-1:0]             slot_rdata_i
);

  ptuc_pkg::state_e state_q, state_d;
  logic [ptuc_pkg::SLOT_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [ptuc_pkg::OWNER_W-1:0] owner_q;

  // captured request
  logic [1:0]                   action_q;
  logic [1:0]                   level_q;
  logic [ptuc_pkg::FRAME_W-1:0] tf_q;
  logic [ptuc_pkg::SLOTF_W-1:0] slot_q;
  logic [ptuc_pkg::FRAME_W-1:0] tg_q;
  logic [2:0]                   nk_q;
  logic                         ns_q;
  logic [ptuc_pkg::OWNER_W-1:0] no_q;

  // result register
  logic                         out_valid_q, out_valid_d;
  logic                         status_q;
  logic [ptuc_pkg::ENTRY_W-1:0] entries_q;
  logic [ptuc_pkg::REF_W-1:0]   refs_q;

  logic accept, go, clr_last, load;
  logic tf_in, tg_in, slot_in;
  logic [2:0] parent_kind, child_kind;
  logic map_ok, unmap_ok, ok, is_table;
  logic [ptuc_pkg::SLOT_DW-1:0] tg_code;
  logic [ptuc_pkg::ENTRY_W-1:0] ent, ent_new;
  logic [ptuc_pkg::REF_W-1:0]   refc, ref_new;
  logic [ptuc_pkg::FRAME_AW-1:0] clr_frame;

  assign accept   = in_valid_i && !in_stall_o;
  assign go       = !out_valid_q || !out_stall_i;
  assign clr_last = clr_cnt_q == ptuc_pkg::SLOT_AW'(ptuc_pkg::SLOT_DEPTH - 1);
  assign clr_frame = clr_cnt_q[ptuc_pkg::SLOT_AW-1:ptuc_pkg::SLOT_IW];

  // owner register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
    end else if (cfg_valid_i) begin
      owner_q <= cfg_data_i;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      level_q  <= level_i;
      tf_q     <= table_frame_i;
      slot_q   <= slot_i;
      tg_q     <= target_frame_i;
      nk_q     <= new_kind_i;
      ns_q     <= new_shared_i;
      no_q     <= new_owner_i;
    end
  end

  // range checks
  assign tf_in   = 32'(tf_q) < ptuc_pkg::FRAME_COUNT;
  assign tg_in   = 32'(tg_q) < ptuc_pkg::FRAME_COUNT;
  assign slot_in = 32'(slot_q) < ptuc_pkg::SLOTS_PER_TABLE;

  // kind rules for the map level
  assign parent_kind = 3'(ptuc_pkg::KIND_L4) + 3'(level_q);
  assign child_kind  = (level_q == 2'd3) ? 3'(ptuc_pkg::KIND_DATA)
                                         : 3'(ptuc_pkg::KIND_L3) + 3'(level_q);
  assign is_table = (tf_word_i.kind == ptuc_pkg::KIND_L4) ||
                    (tf_word_i.kind == ptuc_pkg::KIND_L3) ||
                    (tf_word_i.kind == ptuc_pkg::KIND_L2) ||
                    (tf_word_i.kind == ptuc_pkg::KIND_L1);
  assign tg_code  = ptuc_pkg::SLOT_DW'({1'b0, tg_q} + 10'd1);

  assign map_ok = slot_in && tf_in && tg_in &&
                  (tf_word_i.kind == parent_kind) &&
                  (tg_word_i.kind == child_kind) &&
                  !(tf_word_i.shared && !tg_word_i.shared) &&
                  (tg_word_i.shared || (tg_word_i.owner == owner_q)) &&
                  (tf_word_i.owner == owner_q);

  assign unmap_ok = slot_in && tf_in && tg_in && is_table &&
                    (slot_rdata_i != '0) &&
                    (tf_word_i.owner == owner_q) &&
                    (slot_rdata_i == tg_code);

  // action decode and count update
  assign ent  = tf_word_i.entries;
  assign refc = ref_rdata_i;
  always_comb begin
    ok      = 1'b0;
    ent_new = ent;
    ref_new = refc;
    unique case (action_q)
      ptuc_pkg::ACT_META: begin
        ok = tf_in;
      end
      ptuc_pkg::ACT_MAP: begin
        ok = map_ok;
        if (map_ok) begin
          ent_new = (&ent)  ? ent  : ent + 1'b1;
          ref_new = (&refc) ? refc : refc + 1'b1;
        end
      end
      ptuc_pkg::ACT_UNMAP: begin
        ok = unmap_ok;
        if (unmap_ok) begin
          ent_new = (ent == '0)  ? ent  : ent - 1'b1;
          ref_new = (refc == '0) ? refc : refc - 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // sequencer: clear sweep, accept, execute
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    load        = 1'b0;
    in_stall_o  = 1'b1;
    frame_req_o = '0;
    ref_req_o   = '0;
    slot_req_o  = '0;

    frame_req_o.raddr_tf = ptuc_pkg::FRAME_AW'(table_frame_i);
    frame_req_o.raddr_tg = ptuc_pkg::FRAME_AW'(target_frame_i);
    ref_req_o.raddr      = ptuc_pkg::FRAME_AW'(target_frame_i);
    slot_req_o.raddr     = {ptuc_pkg::FRAME_AW'(table_frame_i),
                            slot_i[ptuc_pkg::SLOT_IW-1:0]};

    unique case (state_q)
      ptuc_pkg::ST_CLEAR: begin
        frame_req_o.we    = 1'b1;
        frame_req_o.waddr = clr_frame;
        ref_req_o.we      = 1'b1;
        ref_req_o.waddr   = clr_frame;
        slot_req_o.we     = 1'b1;
        slot_req_o.waddr  = clr_cnt_q;
        clr_cnt_d         = clr_cnt_q + 1'b1;
        if (clr_last) begin
          state_d = ptuc_pkg::ST_IDLE;
        end
      end
      ptuc_pkg::ST_IDLE: begin
        // input is open here, so a valid request is accepted
        in_stall_o     = 1'b0;
        frame_req_o.re = in_valid_i;
        ref_req_o.re   = in_valid_i;
        slot_req_o.re  = in_valid_i;
        if (in_valid_i) begin
          state_d = ptuc_pkg::ST_EXEC;
        end
      end
      ptuc_pkg::ST_EXEC: begin
        frame_req_o.waddr = ptuc_pkg::FRAME_AW'(tf_q);
        ref_req_o.waddr   = ptuc_pkg::FRAME_AW'(tg_q);
        slot_req_o.waddr  = {ptuc_pkg::FRAME_AW'(tf_q), slot_q[ptuc_pkg::SLOT_IW-1:0]};
        ref_req_o.wdata   = ref_new;
        slot_req_o.wdata  = (action_q == ptuc_pkg::ACT_MAP) ? tg_code : '0;
        if (action_q == ptuc_pkg::ACT_META) begin
          frame_req_o.wdata = '{kind: nk_q, shared: ns_q, owner: no_q, entries: ent};
        end else begin
          frame_req_o.wdata = '{kind: tf_word_i.kind, shared: tf_word_i.shared,
                                owner: tf_word_i.owner, entries: ent_new};
        end
        if (go) begin
          load           = 1'b1;
          frame_req_o.we = ok;
          ref_req_o.we   = ok && (action_q != ptuc_pkg::ACT_META);
          slot_req_o.we  = ok && (action_q != ptuc_pkg::ACT_META);
          state_d        = ptuc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptuc_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ptuc_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q  <= !ok;
      entries_q <= tf_in ? ent_new : '0;
      refs_q    <= tg_in ? ref_new : '0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign table_entries_used_o = entries_q;
  assign target_references_o  = refs_q;

endmodule

### sv/page_table_update_checker.sv
// Result path: memories are read at acceptance; check and write-back follow in
//   the execute state, whose result is registered once the output is not stalled.
// One request at a time: none is accepted until the last leaves the execute state.
// Reset: rst_ni clears control state, then a sweep zeroes the slot memory one
//   entry per cycle, 131072 entries (FRAME_COUNT * 512); requests stall meanwhile.
// The owner register is writable at any time, including during the sweep.
module page_table_update_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ptuc_pkg::OWNER_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [1:0]                   level_i,
  input  logic [ptuc_pkg::FRAME_W-1:0] table_frame_i,
  input  logic [ptuc_pkg::SLOTF_W-1:0] slot_i,
  input  logic [ptuc_pkg::FRAME_W-1:0] target_frame_i,
  input  logic [2:0]                   new_kind_i,
  input  logic                         new_shared_i,
  input  logic [ptuc_pkg::OWNER_W-1:0] new_owner_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         status_o,
  output logic [ptuc_pkg::ENTRY_W-1:0] table_entries_used_o,
  output logic [ptuc_pkg::REF_W-1:0]   target_references_o
);

  ptuc_pkg::frame_req_t  frame_req;
  ptuc_pkg::ref_req_t    ref_req;
  ptuc_pkg::slot_req_t   slot_req;
  ptuc_pkg::frame_word_t tf_word, tg_word;
  logic [ptuc_pkg::REF_W-1:0]   ref_rdata;
  logic [ptuc_pkg::SLOT_DW-1:0] slot_rdata;

  assign cfg_ready_o = 1'b1;

  ptuc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .level_i,
    .table_frame_i,
    .slot_i,
    .target_frame_i,
    .new_kind_i,
    .new_shared_i,
    .new_owner_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .table_entries_used_o,
    .target_references_o,
    .frame_req_o  (frame_req),
    .ref_req_o    (ref_req),
    .slot_req_o   (slot_req),
    .tf_word_i    (tf_word),
    .tg_word_i    (tg_word),
    .ref_rdata_i  (ref_rdata),
    .slot_rdata_i (slot_rdata)
  );

  // frame metadata, two copies written alike for the table and target reads
  ptuc_ram #(
    .Depth (ptuc_pkg::FRAME_COUNT),
    .Width ($bits(ptuc_pkg::frame_word_t))
  ) u_frame_tf (
    .clk_i,
    .re_i    (frame_req.re),
    .raddr_i (frame_req.raddr_tf),
    .we_i    (frame_req.we),
    .waddr_i (frame_req.waddr),
    .wdata_i (frame_req.wdata),
    .rdata_o (tf_word)
  );

  ptuc_ram #(
    .Depth (ptuc_pkg::FRAME_COUNT),
    .Width ($bits(ptuc_pkg::frame_word_t))
  ) u_frame_tg (
    .clk_i,
    .re_i    (frame_req.re),
    .raddr_i (frame_req.raddr_tg),
    .we_i    (frame_req.we),
    .waddr_i (frame_req.waddr),
    .wdata_i (frame_req.wdata),
    .rdata_o (tg_word)
  );

  // reference counts, indexed by target frame
  ptuc_ram #(
    .Depth (ptuc_pkg::FRAME_COUNT),
    .Width (ptuc_pkg::REF_W)
  ) u_refs (
    .clk_i,
    .re_i    (ref_req.re),
    .raddr_i (ref_req.raddr),
    .we_i    (ref_req.we),
    .waddr_i (ref_req.waddr),
    .wdata_i (ref_req.wdata),
    .rdata_o (ref_rdata)
  );

  // slot contents of every table
  ptuc_ram #(
    .Depth (ptuc_pkg::SLOT_DEPTH),
    .Width (ptuc_pkg::SLOT_DW)
  ) u_slots (
    .clk_i,
    .re_i    (slot_req.re),
    .raddr_i (slot_req.raddr),
    .we_i    (slot_req.we),
    .waddr_i (slot_req.waddr),
    .wdata_i (slot_req.wdata),
    .rdata_o (slot_rdata)
  );

endmodule

### sv/ptuc_checker.sv
module ptuc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [ptuc_pkg::OWNER_W-1:0] cfg_data_i,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [1:0]                   action_i,
  input logic [1:0]                   level_i,
  input logic [ptuc_pkg::FRAME_W-1:0] table_frame_i,
  input logic [ptuc_pkg::SLOTF_W-1:0] slot_i,
  input logic [ptuc_pkg::FRAME_W-1:0] target_frame_i,
  input logic [2:0]                   new_kind_i,
  input logic                         new_shared_i,
  input logic [ptuc_pkg::OWNER_W-1:0] new_owner_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         status_o,
  input logic [ptuc_pkg::ENTRY_W-1:0] table_entries_used_o,
  input logic [ptuc_pkg::REF_W-1:0]   target_references_o
);

  // one transaction in flight: stall right after an accepted request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request channel open while a transaction is in flight");

  // a new result follows the execute cycle, during which requests stall
  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a preceding execute cycle");

  // owner register is always writable
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("owner register write refused");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o) &&
      $stable(table_entries_used_o) && $stable(target_references_o)))
    else $error("stalled result changed");

endmodule

bind page_table_update_checker ptuc_checker u_ptuc_checker (.*);
